[hdl/mov_pkg.sv]
// Shared widths, codes and constants for the modulated oscillator voice.
package mov_pkg;

  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;

  localparam int VAL_W      = 16;
  localparam int MODE_W     = 4;
  localparam int ACC_W      = 24;
  localparam int GAIN_W     = 26;
  localparam int BASE_W     = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_WAVE = 2'd0;
  localparam cfg_idx_t CFG_BASE = 2'd1;

  typedef logic [1:0] wave_t;
  localparam wave_t WAVE_SINE     = 2'd0;
  localparam wave_t WAVE_TRIANGLE = 2'd1;
  localparam wave_t WAVE_RAMP     = 2'd2;
  localparam wave_t WAVE_SQUARE   = 2'd3;

  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_FM_EXP    = 4'd0;
  localparam mode_t MODE_FM_AC     = 4'd1;
  localparam mode_t MODE_FM_LIN    = 4'd2;
  localparam mode_t MODE_FM_TZ     = 4'd3;
  localparam mode_t MODE_PM        = 4'd4;
  localparam mode_t MODE_AM        = 4'd5;
  localparam mode_t MODE_AM_OFFSET = 4'd6;
  localparam mode_t MODE_AM_RECT   = 4'd7;
  localparam mode_t MODE_RING      = 4'd8;

  localparam logic [BASE_W-1:0]        BASE_RESET = 31'd85701343;
  localparam logic signed [MUL_W-1:0]  DC_K       = 34'sd2517;
  localparam logic signed [MUL_W-1:0]  ONE_Q29    = 34'sd536870912;
  localparam logic signed [GAIN_W-1:0] GAIN_ONE   = 26'sd1048576;
  localparam logic signed [29:0]       GAIN_LIM   = 30'sd16777216;
  localparam logic signed [ACC_W-1:0]  EXP_LIM    = 24'sd524288;
  localparam logic signed [41:0]       NYQ_INC    = 42'sd2061584302;
  localparam logic signed [47:0]       OUT_LIM    = 48'sd16384;

endpackage

[hdl/mov_if.sv]
// Channel interfaces: sample rows in, samples out, configuration writes.
interface mov_in_if import mov_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    has_row;
  logic signed [VAL_W-1:0] mod_value;
  logic signed [VAL_W-1:0] mod_amount;
  logic [MODE_W-1:0]       mod_mode;
  logic                    last_row;
  modport source (output valid, has_row, mod_value, mod_amount, mod_mode, last_row,
                  input ready);
  modport sink (input valid, has_row, mod_value, mod_amount, mod_mode, last_row,
                output ready);
endinterface

interface mov_out_if import mov_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] sample_out;
  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface

interface mov_cfg_if import mov_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/mov_mul.sv]
// Shared signed multiplier with registered product.
module mov_mul import mov_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

[hdl/modulated_oscillator_voice_unit.sv]
// Phase-accumulator voice with per-row FM/PM/AM modulation, a sine table and computed waveforms.
//
// Channels: item (sink) carries one modulation row per transaction; result
// (source) carries one sample per finished sample; cfg (sink) writes
// wave_select (index 0) and base_increment (index 1), always ready.
// A sample is one or more row transactions; last_row, or an item with
// has_row low, ends it and produces exactly one result transaction.
// A row is accepted, runs the DC tracker (multiply, update), then
// accumulates if its amount is nonzero, plus a gain step for gain modes;
// the sample end then reads the exponent table, forms two products, updates
// the phase, reads the shape and forms the output product.
// Every product goes through one shared 34x34 multiplier. item.ready is
// high only while the sequencer is idle.
// The finished sample sits in an output register; if result stalls, the
// sequencer waits in its last step until the register frees up.
// Reset: phase 0, DC trackers 0, sums cleared, gain 1.0, sine, default base
// increment; reset is synchronous and needs no clearing pass.
module modulated_oscillator_voice_unit import mov_pkg::*; #(
  parameter int MAX_ROWS         = 8,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int EXP_TABLE_DEPTH  = 256,
  parameter int PHASE_BITS       = 32
) (
  input logic        clk,
  input logic        rst,
  mov_in_if.sink     item,
  mov_out_if.source  result,
  mov_cfg_if.sink    cfg
);

  localparam int RI_W  = $clog2(MAX_ROWS + 1);
  localparam int DCI_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SL    = $clog2(SINE_TABLE_DEPTH);
  localparam int EL    = $clog2(EXP_TABLE_DEPTH);
  localparam int PB    = PHASE_BITS;
  localparam int SH_UP = (PB >= 32) ? PB - 32 : 0;
  localparam int SH_DN = (PB < 32) ? 32 - PB : 0;
  localparam int PM_UP = (PB >= 22) ? PB - 22 : 0;
  localparam int PM_DN = (PB < 22) ? 22 - PB : 0;
  localparam logic [RI_W-1:0] ROWS = RI_W'(MAX_ROWS);
  localparam logic [PB-1:0]   HALF = {1'b1, {(PB-1){1'b0}}};

  typedef logic signed [15:0] sine_tab_t [SINE_TABLE_DEPTH];
  typedef logic [30:0]        exp_tab_t [EXP_TABLE_DEPTH];

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_DC_MUL  = 11'b00000000010,
    S_DC_UPD  = 11'b00000000100,
    S_ACC     = 11'b00000001000,
    S_GAIN    = 11'b00000010000,
    S_F_LIN   = 11'b00000100000,
    S_F_EXP   = 11'b00001000000,
    S_F_INC   = 11'b00010000000,
    S_F_RD    = 11'b00100000000,
    S_F_SHAPE = 11'b01000000000,
    S_F_OUT   = 11'b10000000000
  } state_t;

  function automatic logic [63:0] exp2_frac(logic [63:0] f);
    logic [63:0] r;
    r = 64'd84825604;
    r = 64'd241914033 + ((r * f) >> 30);
    r = 64'd747002187 + ((r * f) >> 30);
    return (64'd1 << 30) + ((r * f) >> 30);
  endfunction

  function automatic exp_tab_t exp_init();
    exp_tab_t    t;
    logic [63:0] f;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      f = 64'(k) << (30 - EL);
      t[k] = 31'(exp2_frac(f));
    end
    return t;
  endfunction

  function automatic logic signed [15:0] sine_quarter(logic [63:0] u);
    logic [63:0] s;
    logic [63:0] p;
    s = (u * u) >> 30;
    p = 64'd172228;
    p = 64'd5027044 - ((p * s) >> 30);
    p = 64'd85569278 - ((p * s) >> 30);
    p = 64'd693598677 - ((p * s) >> 30);
    p = 64'd1686629713 - ((p * s) >> 30);
    p = (p * u) >> 30;
    p = (p + 64'd32768) >> 16;
    return (p > 64'd16384) ? 16'sd16384 : 16'(p);
  endfunction

  function automatic sine_tab_t sine_init();
    sine_tab_t          t;
    logic [63:0]        ph;
    logic [63:0]        fr;
    logic [63:0]        u;
    logic signed [15:0] s;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      ph = 64'(k) << (32 - SL);
      fr = {34'd0, ph[29:0]};
      u  = ph[30] ? ((64'd1 << 30) - fr) : fr;
      s  = sine_quarter(u);
      t[k] = ph[31] ? -s : s;
    end
    return t;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat24(logic signed [26:0] x);
    if (x > 27'sd8388607) begin
      return 24'sd8388607;
    end else if (x < -27'sd8388608) begin
      return -24'sd8388608;
    end
    return 24'(x);
  endfunction

  localparam sine_tab_t SINE_ROM = sine_init();
  localparam exp_tab_t  EXP_ROM  = exp_init();

  state_t state, state_next;

  logic                    last_r;
  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] amt_r;
  mode_t                   mode_r;

  logic [RI_W-1:0]         ri;
  logic signed [ACC_W-1:0] dc [MAX_ROWS];
  logic signed [ACC_W-1:0] exp_sum;
  logic signed [ACC_W-1:0] lin_sum;
  logic [ACC_W-1:0]        pm_sum;
  logic signed [GAIN_W-1:0] gain;
  logic                    tz;
  logic [PB-1:0]           phase;
  wave_t                   wave;
  logic [BASE_W-1:0]       base;

  logic signed [4:0]       ip_r;
  logic [30:0]             mant_q;
  logic signed [39:0]      linterm_r;
  logic signed [15:0]      sine_q;
  logic signed [15:0]      shape_r;

  logic                    out_valid;
  logic signed [VAL_W-1:0] out_data;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;

  mov_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  // row datapath
  logic [DCI_W-1:0]        dc_idx;
  logic signed [ACC_W-1:0] dc_cur;
  logic signed [ACC_W-1:0] v256;
  logic signed [24:0]      dc_diff;
  logic signed [ACC_W-1:0] dc_new;
  logic signed [25:0]      ac_x;
  logic signed [16:0]      abs_v;
  logic signed [16:0]      abs_a;
  logic signed [17:0]      v_m;
  logic signed [17:0]      absv_m;
  logic signed [MUL_W-1:0] mode_x;
  logic signed [MUL_W-1:0] prod34;
  logic signed [MUL_W-1:0] gain_f;
  logic signed [26:0]      exp_term;
  logic signed [ACC_W-1:0] exp_nx;
  logic signed [ACC_W-1:0] lin_nx;
  logic [ACC_W-1:0]        pm_nx;
  logic signed [29:0]      gain_p;
  logic signed [GAIN_W-1:0] gain_nx;
  logic                    gain_mode;
  logic                    row_ok;

  assign dc_idx  = ri[DCI_W-1:0];
  assign dc_cur  = dc[dc_idx];
  assign v256    = {val_r, 8'd0};
  assign dc_diff = 25'(v256) - 25'(dc_cur);
  assign dc_new  = dc_cur + 24'(mul_p >>> 22);
  assign ac_x    = 26'(v256) - 26'(dc_new);
  assign abs_v   = (val_r < 0) ? -17'(val_r) : 17'(val_r);
  assign abs_a   = (amt_r < 0) ? -17'(amt_r) : 17'(amt_r);
  assign v_m     = 18'(val_r) - 18'sd16384;
  assign absv_m  = 18'(abs_v) - 18'sd16384;
  assign prod34  = 34'(mul_p);
  assign gain_mode = (mode_r >= MODE_AM);
  assign row_ok  = item.has_row && (ri < ROWS);

  always_comb begin
    case (mode_r) inside
      MODE_FM_AC:   mode_x = 34'(ac_x);
      MODE_AM:      mode_x = 34'(v_m);
      MODE_AM_RECT: mode_x = 34'(absv_m);
      default:      mode_x = 34'(val_r);
    endcase
    case (mode_r) inside
      MODE_AM, MODE_AM_OFFSET: gain_f = ONE_Q29 + prod34;
      MODE_AM_RECT:            gain_f = ONE_Q29 + (prod34 <<< 1);
      default:                 gain_f = ONE_Q29 - (34'(abs_a) <<< 15) + (prod34 <<< 1);
    endcase
  end

  assign exp_term = (mode_r == MODE_FM_AC) ? 27'(mul_p >>> 19) : 27'(mul_p >>> 11);
  assign exp_nx   = sat24(27'(exp_sum) + exp_term);
  assign lin_nx   = sat24(27'(lin_sum) + 27'(mul_p >>> 10));
  assign pm_nx    = pm_sum + 24'(mul_p >>> 6);
  assign gain_p   = 30'(mul_p >>> 29);
  assign gain_nx  = (gain_p > GAIN_LIM) ? 26'(GAIN_LIM) :
                    (gain_p < -GAIN_LIM) ? 26'(-GAIN_LIM) : 26'(gain_p);

  // sample-end datapath
  logic signed [ACC_W-1:0] e_cl;
  logic [EL-1:0]           eidx;
  logic [61:0]             ep;
  logic [5:0]              esh;
  logic [40:0]             eterm;
  logic signed [41:0]      inc_raw;
  logic signed [41:0]      inc_pos;
  logic signed [41:0]      inc_cl;
  logic signed [63:0]      step64;
  logic [63:0]             pmp;
  logic [PB-1:0]           rd;
  logic [PB-1:0]           half_dev;
  logic [16:0]             tri_v;
  logic [14:0]             saw_v;
  logic signed [15:0]      shape_nx;
  logic signed [15:0]      shape;
  logic signed [47:0]      out_p;
  logic signed [VAL_W-1:0] out_nx;
  logic                    can_load;

  assign e_cl    = (exp_sum > EXP_LIM) ? EXP_LIM : (exp_sum < -EXP_LIM) ? -EXP_LIM : exp_sum;
  assign eidx    = e_cl[15 -: EL];
  assign ep      = mul_p[61:0];
  assign esh     = 6'(7'sd30 - 7'(ip_r));
  assign eterm   = 41'(ep >> esh);
  assign inc_raw = $signed({1'b0, eterm}) + 42'(linterm_r);
  assign inc_pos = (!tz && inc_raw < 0) ? 42'sd0 : inc_raw;
  assign inc_cl  = (inc_pos > NYQ_INC) ? NYQ_INC : (inc_pos < -NYQ_INC) ? -NYQ_INC : inc_pos;
  assign step64  = (64'(32'(inc_cl)) <<< SH_UP) >>> SH_DN;
  assign pmp     = (64'(pm_sum[21:0]) << PM_UP) >> PM_DN;
  assign rd      = phase + pmp[PB-1:0];
  assign half_dev = (rd >= HALF) ? rd - HALF : HALF - rd;
  assign tri_v   = 17'(half_dev >> (PB - 16));
  assign saw_v   = 15'(rd >> (PB - 15));
  assign shape   = (wave == WAVE_SINE) ? sine_q : shape_r;
  assign out_p   = 48'(mul_p >>> 20);
  assign out_nx  = (out_p > OUT_LIM) ? 16'sd16384 : (out_p < -OUT_LIM) ? -16'sd16384 : 16'(out_p);
  assign can_load = !out_valid || result.ready;

  always_comb begin
    case (wave)
      WAVE_TRIANGLE: shape_nx = 16'($signed({1'b0, tri_v}) - 18'sd16384);
      WAVE_RAMP:     shape_nx = $signed({1'b0, saw_v}) - 16'sd16384;
      default:       shape_nx = rd[PB-1] ? -16'sd16384 : 16'sd16384;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_DC_MUL: begin
        mul_a = 34'(dc_diff);
        mul_b = DC_K;
      end
      S_DC_UPD: begin
        mul_a = 34'(amt_r);
        mul_b = mode_x;
      end
      S_ACC: begin
        mul_a = 34'(gain);
        mul_b = gain_f;
      end
      S_F_LIN: begin
        mul_a = $signed({3'd0, base});
        mul_b = 34'(lin_sum);
      end
      S_F_EXP: begin
        mul_a = $signed({3'd0, base});
        mul_b = $signed({3'd0, mant_q});
      end
      S_F_SHAPE, S_F_OUT: begin
        mul_a = 34'(shape);
        mul_b = 34'(gain);
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item.valid) begin
          if (row_ok) begin
            state_next = S_DC_MUL;
          end else if (!item.has_row || item.last_row) begin
            state_next = S_F_LIN;
          end
        end
      end
      S_DC_MUL: state_next = S_DC_UPD;
      S_DC_UPD: begin
        if (amt_r != '0) begin
          state_next = S_ACC;
        end else begin
          state_next = last_r ? S_F_LIN : S_IDLE;
        end
      end
      S_ACC: begin
        if (gain_mode) begin
          state_next = S_GAIN;
        end else begin
          state_next = last_r ? S_F_LIN : S_IDLE;
        end
      end
      S_GAIN:    state_next = last_r ? S_F_LIN : S_IDLE;
      S_F_LIN:   state_next = S_F_EXP;
      S_F_EXP:   state_next = S_F_INC;
      S_F_INC:   state_next = S_F_RD;
      S_F_RD:    state_next = S_F_SHAPE;
      S_F_SHAPE: state_next = S_F_OUT;
      S_F_OUT: begin
        if (can_load) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ri        <= '0;
      exp_sum   <= '0;
      lin_sum   <= '0;
      pm_sum    <= '0;
      gain      <= GAIN_ONE;
      tz        <= 1'b0;
      phase     <= '0;
      wave      <= WAVE_SINE;
      base      <= BASE_RESET;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_ROWS; i++) begin
        dc[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_WAVE: wave <= cfg.data[1:0];
          CFG_BASE: base <= cfg.data[BASE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_DC_UPD: begin
          dc[dc_idx] <= dc_new;
          ri         <= ri + 1'b1;
        end
        S_ACC: begin
          case (mode_r) inside
            MODE_FM_EXP, MODE_FM_AC: exp_sum <= exp_nx;
            MODE_FM_LIN:             lin_sum <= lin_nx;
            MODE_FM_TZ: begin
              lin_sum <= lin_nx;
              tz      <= 1'b1;
            end
            MODE_PM:                 pm_sum <= pm_nx;
            default: ;
          endcase
        end
        S_GAIN:  gain  <= gain_nx;
        S_F_INC: phase <= phase + step64[PB-1:0];
        S_F_OUT: begin
          if (can_load) begin
            out_valid <= 1'b1;
            exp_sum   <= '0;
            lin_sum   <= '0;
            pm_sum    <= '0;
            gain      <= GAIN_ONE;
            tz        <= 1'b0;
            ri        <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && item.valid) begin
      last_r <= item.last_row;
      val_r  <= item.mod_value;
      amt_r  <= item.mod_amount;
      mode_r <= item.mod_mode;
    end
    if (state == S_F_LIN) begin
      ip_r   <= e_cl[20:16];
      mant_q <= EXP_ROM[eidx];
    end
    if (state == S_F_EXP) begin
      linterm_r <= 40'(mul_p >>> 16);
    end
    if (state == S_F_RD) begin
      sine_q  <= SINE_ROM[rd[PB-1 -: SL]];
      shape_r <= shape_nx;
    end
    if (state == S_F_OUT && can_load) begin
      out_data <= out_nx;
    end
  end

  assign item.ready        = (state == S_IDLE);
  assign cfg.ready         = 1'b1;
  assign result.valid      = out_valid;
  assign result.sample_out = out_data;

endmodule
